FILE: sv/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF      = 1024;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int OP_W           = 3;
    localparam int VALUE_W        = 32;
    localparam int COUNT_W        = 11;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_POP_FRONT  = 3'd1,
        OP_PUSH_FRONT = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } st_t;

    // Result bookkeeping handed from the control stage to the output stage.
    typedef struct packed {
        logic               is_read;
        st_t                status;
        logic [COUNT_W-1:0] count;
    } res_info_t;

endpackage
`default_nettype wire

FILE: sv/deq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram
// Ring storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic                  clk,
    input  wire logic                  we,
    input  wire logic [AW-1:0]         waddr,
    input  wire logic [DATA_WIDTH-1:0] wdata,
    input  wire logic                  re,
    input  wire logic [AW-1:0]         raddr,
    output logic      [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: sv/deq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl
// Head/tail/count registers, status decode and ring memory access.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [deq_pkg::OP_W-1:0]     opcode,
    input  wire logic [deq_pkg::VALUE_W-1:0]  push_value,
    input  wire logic                         pend_take,
    output logic                              pend_valid,
    output deq_pkg::res_info_t                pend_info,
    output logic      [DATA_WIDTH-1:0]        rd_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = (DATA_WIDTH > deq_pkg::VALUE_W) ? DATA_WIDTH : deq_pkg::VALUE_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          pend_valid_reg;
    deq_pkg::res_info_t pend_info_reg;

    logic          accept;
    logic          we_c, re_c;
    logic [AW-1:0] addr_c;
    logic [AW-1:0] head_inc, head_dec, tail_inc, tail_dec;
    logic          full, empty;
    deq_pkg::st_t  st_c;
    logic [XW-1:0] push_ext;

    assign in_stall = pend_valid_reg && !pend_take;
    assign accept   = in_valid && !in_stall;

    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - 1'b1;
    assign tail_inc = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign tail_dec = (tail_reg == '0) ? LAST_IDX : tail_reg - 1'b1;
    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign push_ext = XW'(push_value);

    always_comb
    begin
        we_c      = 1'b0;
        re_c      = 1'b0;
        addr_c    = head_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        st_c      = deq_pkg::ST_OK;
        case (deq_pkg::op_t'(opcode))
            deq_pkg::OP_PUSH_BACK:
            begin
                if (full)
                begin
                    st_c = deq_pkg::ST_FULL;
                end
                else
                begin
                    we_c      = 1'b1;
                    addr_c    = tail_reg;
                    tail_next = tail_inc;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            deq_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                begin
                    st_c = deq_pkg::ST_FULL;
                end
                else
                begin
                    we_c      = 1'b1;
                    addr_c    = head_dec;
                    head_next = head_dec;
                    cnt_next  = cnt_reg + 1'b1;
                end
            end
            deq_pkg::OP_POP_FRONT:
            begin
                if (empty)
                begin
                    st_c = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    re_c      = 1'b1;
                    addr_c    = head_reg;
                    head_next = head_inc;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            deq_pkg::OP_POP_BACK:
            begin
                if (empty)
                begin
                    st_c = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    re_c      = 1'b1;
                    addr_c    = tail_dec;
                    tail_next = tail_dec;
                    cnt_next  = cnt_reg - 1'b1;
                end
            end
            deq_pkg::OP_PEEK_FRONT:
            begin
                if (empty)
                begin
                    st_c = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    re_c   = 1'b1;
                    addr_c = head_reg;
                end
            end
            deq_pkg::OP_PEEK_BACK:
            begin
                if (empty)
                begin
                    st_c = deq_pkg::ST_EMPTY;
                end
                else
                begin
                    re_c   = 1'b1;
                    addr_c = tail_dec;
                end
            end
            default:
            begin
                st_c = deq_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            cnt_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                head_reg <= head_next;
                tail_reg <= tail_next;
                cnt_reg  <= cnt_next;
            end
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (pend_take)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_info_reg.is_read <= re_c;
            pend_info_reg.status  <= st_c;
            pend_info_reg.count   <= deq_pkg::COUNT_W'(cnt_next);
        end
    end

    assign pend_valid = pend_valid_reg;
    assign pend_info  = pend_info_reg;

    deq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (accept && we_c),
        .waddr (addr_c),
        .wdata (push_ext[DATA_WIDTH-1:0]),
        .re    (accept && re_c),
        .raddr (addr_c),
        .rdata (rd_data)
    );

endmodule
`default_nettype wire

FILE: sv/double_ended_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Double-ended queue of data words in a ring memory of DEPTH entries.
//
// Input channel (in_valid/in_stall): opcode and push_value. Output channel
// (out_valid/out_stall): read_value, status and count; every input
// transaction yields exactly one output transaction, in order.
// Throughput: one transaction per cycle while out_stall is low. The control
// stage updates head, tail and count at acceptance and issues the ring
// memory access in the same cycle; the read data is registered in the
// memory's read port and then loaded into the output register.
// When the receiver stalls, the output register holds; one more result can
// wait in the control stage, after which in_stall rises until out_stall
// drops.
// Reset clears head, tail, count and all valid flags; memory contents stay
// undefined and no clearing pass is needed. Input is accepted as soon as reset is released.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [deq_pkg::OP_W-1:0]     opcode,
    input  wire logic [deq_pkg::VALUE_W-1:0]  push_value,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [deq_pkg::VALUE_W-1:0]  read_value,
    output logic      [1:0]                   status,
    output logic      [deq_pkg::COUNT_W-1:0]  count
);

    localparam int XW = (DATA_WIDTH > deq_pkg::VALUE_W) ? DATA_WIDTH : deq_pkg::VALUE_W;

    logic                  pend_valid;
    logic                  pend_take;
    deq_pkg::res_info_t    pend_info;
    logic [DATA_WIDTH-1:0] rd_data;
    logic [XW-1:0]         rd_ext;

    logic                          out_valid_reg;
    logic [deq_pkg::VALUE_W-1:0]   read_value_reg;
    deq_pkg::st_t                  status_reg;
    logic [deq_pkg::COUNT_W-1:0]   count_reg;

    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .push_value (push_value),
        .pend_take  (pend_take),
        .pend_valid (pend_valid),
        .pend_info  (pend_info),
        .rd_data    (rd_data)
    );

    assign pend_take = pend_valid && (!out_valid_reg || !out_stall);
    assign rd_ext    = XW'(rd_data);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pend_take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_take)
        begin
            read_value_reg <= pend_info.is_read ? rd_ext[deq_pkg::VALUE_W-1:0] : '0;
            status_reg     <= pend_info.status;
            count_reg      <= pend_info.count;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign count      = count_reg;

`ifndef SYNTH
    a_stall_only_when_output_blocked: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall)
    ) else $error("input stalled while output stage could drain");

    a_error_reads_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status != deq_pkg::ST_OK) |-> (read_value == '0)
    ) else $error("nonzero read_value with error status");

    a_empty_count_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status == deq_pkg::ST_EMPTY) |-> (count == '0)
    ) else $error("empty status with nonzero count");

    a_full_count_depth: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && status == deq_pkg::ST_FULL) |->
            (count == deq_pkg::COUNT_W'(DEPTH))
    ) else $error("full status with count below depth");
`endif

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for double_ended_queue.
//
// Runs directed transactions at both ends of the ring (empty reads, pointer
// wrap in both directions, extreme data words, unused opcodes), then a random
// mix, a long receiver hold-off, a fill to full with probes at full, and a
// final stretch without idling. A shadow deque predicts read value, status
// and count per accepted transaction; the output monitor compares in order.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int RING_DEPTH = deq_pkg::DEPTH_DEF;
    localparam int WDOG_LIMIT = 2000;
    localparam int HOLD_LEN   = 300;
    localparam int TAIL_WAIT  = 8;

    typedef logic [deq_pkg::OP_W-1:0] opc_t;

    localparam opc_t OP_RSVD_A = 3'd6;
    localparam opc_t OP_RSVD_B = 3'd7;

    typedef struct {
        logic [deq_pkg::VALUE_W-1:0] rd;
        deq_pkg::st_t                st;
        logic [deq_pkg::COUNT_W-1:0] cnt;
    } deq_result_t;

    logic                        clk        = 1'b0;
    logic                        rst_n      = 1'b0;
    logic                        in_valid   = 1'b0;
    logic [deq_pkg::OP_W-1:0]    opcode     = '0;
    logic [deq_pkg::VALUE_W-1:0] push_value = '0;
    logic                        out_stall  = 1'b0;
    logic                        in_stall;
    logic                        out_valid;
    logic [deq_pkg::VALUE_W-1:0] read_value;
    logic [1:0]                  status;
    logic [deq_pkg::COUNT_W-1:0] count;

    // shadow deque
    logic [deq_pkg::VALUE_W-1:0] shadow_ring [RING_DEPTH];
    int unsigned        shadow_head  = 0;
    int unsigned        shadow_tail  = 0;
    int unsigned        shadow_level = 0;

    deq_result_t        pending_results[$];
    int                 error_count  = 0;
    int                 result_index = 0;
    int                 stall_free   = 0;
    bit                 tx_idle_en   = 1'b1;
    bit                 rx_idle_en   = 1'b1;
    int                 rx_hold_left = 0;
    int                 rx_burst_left = 0;

    double_ended_queue dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .opcode     (opcode),
        .push_value (push_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_value (read_value),
        .status     (status),
        .count      (count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void shadow_apply(input logic [deq_pkg::OP_W-1:0] op,
                                         input logic [deq_pkg::VALUE_W-1:0] val);
        deq_result_t res;
        res.rd = '0;
        res.st = deq_pkg::ST_OK;
        if ((op == deq_pkg::OP_PUSH_BACK || op == deq_pkg::OP_PUSH_FRONT)
            && shadow_level == RING_DEPTH)
            res.st = deq_pkg::ST_FULL;
        else if (op inside {deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK,
                            deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK}
                 && shadow_level == 0)
            res.st = deq_pkg::ST_EMPTY;
        else
        begin
            case (op)
                deq_pkg::OP_PUSH_BACK:
                begin
                    shadow_ring[shadow_tail] = val;
                    shadow_tail = (shadow_tail + 1) % RING_DEPTH;
                    shadow_level++;
                end
                deq_pkg::OP_POP_FRONT:
                begin
                    res.rd = shadow_ring[shadow_head];
                    shadow_head = (shadow_head + 1) % RING_DEPTH;
                    shadow_level--;
                end
                deq_pkg::OP_PUSH_FRONT:
                begin
                    shadow_head = (shadow_head + RING_DEPTH - 1) % RING_DEPTH;
                    shadow_ring[shadow_head] = val;
                    shadow_level++;
                end
                deq_pkg::OP_POP_BACK:
                begin
                    shadow_tail = (shadow_tail + RING_DEPTH - 1) % RING_DEPTH;
                    res.rd = shadow_ring[shadow_tail];
                    shadow_level--;
                end
                deq_pkg::OP_PEEK_FRONT:
                    res.rd = shadow_ring[shadow_head];
                deq_pkg::OP_PEEK_BACK:
                    res.rd = shadow_ring[(shadow_tail + RING_DEPTH - 1) % RING_DEPTH];
                default:
                    ;
            endcase
        end
        res.cnt = shadow_level[deq_pkg::COUNT_W-1:0];
        pending_results.push_back(res);
    endfunction

    function automatic logic [deq_pkg::VALUE_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic opc_t rand_op(input int unsigned hi);
        return opc_t'($urandom_range(0, hi));
    endfunction

    // called just after a rising edge; returns at the edge of acceptance
    task automatic send_item(input logic [deq_pkg::OP_W-1:0] op,
                             input logic [deq_pkg::VALUE_W-1:0] val);
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        push_value <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        shadow_apply(op, val);
    endtask

    task automatic wait_all_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_mismatch(input string field,
                                   input logic [deq_pkg::VALUE_W-1:0] got,
                                   input logic [deq_pkg::VALUE_W-1:0] want);
        $display("mismatch: result %0d %s got 0x%0h expected 0x%0h",
                 result_index, field, got, want);
        error_count++;
    endtask

    // result monitor
    always @(posedge clk)
    begin
        deq_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected transaction", read_value, '0);
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.rd)
                    report_mismatch("read_value", read_value, want.rd);
                if (status !== want.st)
                    report_mismatch("status", {30'd0, status}, {30'd0, want.st});
                if (count !== want.cnt)
                    report_mismatch("count", {21'd0, count}, {21'd0, want.cnt});
            end
            result_index++;
        end
    end

    // receiver stall: long hold-off first, then random bursts
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (rx_hold_left > 0)
        begin
            out_stall    <= 1'b1;
            rx_hold_left <= rx_hold_left - 1;
        end
        else if (rx_burst_left > 0)
        begin
            out_stall     <= 1'b1;
            rx_burst_left <= rx_burst_left - 1;
        end
        else if (rx_idle_en && $urandom_range(0, 5) == 0)
        begin
            out_stall     <= 1'b1;
            rx_burst_left <= $urandom_range(0, 3);
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            stall_free <= 0;
        else
            stall_free <= stall_free + 1;
        if (stall_free >= WDOG_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles", WDOG_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic test_empty_reads();
        send_item(deq_pkg::OP_POP_FRONT, '1);
        send_item(deq_pkg::OP_POP_BACK, '0);
        send_item(deq_pkg::OP_PEEK_FRONT, $urandom);
        send_item(deq_pkg::OP_PEEK_BACK, $urandom);
    endtask

    task automatic test_directed_ops();
        send_item(deq_pkg::OP_PUSH_FRONT, '1);          // head wraps below zero
        send_item(deq_pkg::OP_PUSH_BACK, '0);
        send_item(deq_pkg::OP_PUSH_BACK, 32'h8000_0001);
        send_item(deq_pkg::OP_PEEK_FRONT, $urandom);
        send_item(deq_pkg::OP_PEEK_BACK, $urandom);
        send_item(OP_RSVD_A, '1);
        send_item(OP_RSVD_B, $urandom);
        send_item(deq_pkg::OP_POP_BACK, $urandom);
        send_item(deq_pkg::OP_POP_FRONT, $urandom);
        send_item(deq_pkg::OP_PUSH_FRONT, 32'h5A5A_A5A5);
        send_item(deq_pkg::OP_POP_FRONT, $urandom);
        send_item(deq_pkg::OP_POP_BACK, $urandom);
        send_item(deq_pkg::OP_POP_BACK, $urandom);
        send_item(OP_RSVD_A, '0);
        wait_all_results();
        @(posedge clk);
        // tail wraps below zero
        send_item(deq_pkg::OP_PUSH_FRONT, 32'h0123_4567);
        send_item(deq_pkg::OP_PUSH_FRONT, 32'hFEDC_BA98);
        send_item(deq_pkg::OP_PEEK_BACK, $urandom);
        send_item(deq_pkg::OP_POP_BACK, $urandom);
        send_item(deq_pkg::OP_POP_BACK, $urandom);
        send_item(deq_pkg::OP_PEEK_FRONT, $urandom);
    endtask

    task automatic test_random_mix(input int n);
        repeat (n)
            send_item(rand_op(7), rand_word());
    endtask

    task automatic test_rx_hold();
        in_valid <= 1'b0;
        @(negedge clk);
        rx_hold_left = HOLD_LEN;
        @(posedge clk);
        repeat (40)
            send_item(rand_op(5), rand_word());
        wait_all_results();
        @(posedge clk);
    endtask

    task automatic test_fill_to_full();
        logic [deq_pkg::OP_W-1:0] op;
        while (shadow_level < RING_DEPTH)
        begin
            if ($urandom_range(0, 9) != 0)
                op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT;
            else
                op = rand_op(7);
            send_item(op, rand_word());
        end
        repeat (12)
        begin
            case ($urandom_range(0, 3))
                0:       op = deq_pkg::OP_PEEK_FRONT;
                1:       op = deq_pkg::OP_PEEK_BACK;
                2:       op = deq_pkg::OP_PUSH_FRONT;
                default: op = deq_pkg::OP_PUSH_BACK;
            endcase
            send_item(op, rand_word());
        end
    endtask

    task automatic test_back_to_back();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        repeat (150)
            send_item(rand_op(7), rand_word());
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_reads();
        test_directed_ops();
        test_random_mix(150);
        test_rx_hold();
        test_fill_to_full();
        test_back_to_back();
        wait_all_results();
        repeat (TAIL_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
